>>> design/spq_pkg.sv
// Package: shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Command codes
  localparam logic [1:0] CMD_STATUS = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned DATA_W = 32;

  // One held entry
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell for the current command
  typedef struct packed {
    logic   do_insert;
    logic   do_remove;
    entry_t new_entry;
  } cell_ctrl_t;

  // Per-cell compare results
  typedef struct packed {
    logic ge;     // held entry is behind the newcomer
    logic shift;  // newcomer lands here or further ahead (cell moves right)
  } cell_stat_t;

endpackage

>>> design/spq_cell.sv
// One slot of the sorted shift-register queue.
`timescale 1ns / 1ps

module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                strict_cmp,
  input  logic                valid,
  input  spq_pkg::entry_t     left_entry,
  input  logic                left_shift,
  input  spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t     entry,
  output spq_pkg::entry_t     entry_next,
  output spq_pkg::cell_stat_t stat
);

  logic ge;

  // Front cell yields only to a strictly smaller priority
  always_comb begin
    if (strict_cmp) begin
      ge = valid && ($signed(entry.prio) > $signed(ctrl.new_entry.prio));
    end else begin
      ge = valid && ($signed(entry.prio) >= $signed(ctrl.new_entry.prio));
    end
  end

  assign stat.ge    = ge;
  assign stat.shift = ge || !valid;

  // Insert: take left neighbor if it moves, else newcomer at the boundary; remove: take right neighbor
  always_comb begin
    if (ctrl.do_insert) begin
      if (left_shift) begin
        entry_next = left_entry;
      end else if (stat.shift) begin
        entry_next = ctrl.new_entry;
      end else begin
        entry_next = entry;
      end
    end else if (ctrl.do_remove) begin
      entry_next = right_entry;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

>>> design/sorted_priority_queue.sv
// Top level: bounded priority queue built from a row of sorted cells.
//
// Input channel (in_valid / in_stall) carries one command per transfer:
// cmd, item_value, item_priority. Output channel (out_valid / out_stall)
// returns one result per command: status, entry_count, is_empty and the
// front and back entries (zeros when empty).
// Every cell compares its priority with the newcomer in parallel and
// shifts toward its neighbor in the same cycle, so a command is applied
// to all cells together and its result is registered: out_valid rises in
// the cycle after the input transfer, and one command per cycle is
// accepted while the receiver keeps taking results.
// The result register holds a single result; while it is full and
// out_stall is high, in_stall is raised and the queue state holds.
// Reset empties the queue (count zero) and drops any pending result;
// cell contents are not cleared, since only held slots are ever read.
// A newcomer that ties with the front entry goes behind it, but goes
// ahead of the first entry further back whose priority is equal or greater.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] item_value,
  input  logic signed [31:0] item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [4:0]         entry_count,
  output logic               is_empty,
  output logic signed [31:0] front_value,
  output logic signed [31:0] front_priority,
  output logic signed [31:0] back_value,
  output logic signed [31:0] back_priority
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic                 accept;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [1:0]           status_next;
  spq_pkg::entry_t      back;
  spq_pkg::entry_t      back_next;
  spq_pkg::entry_t      new_entry;
  spq_pkg::cell_ctrl_t  ctrl;
  spq_pkg::entry_t      cell_entry [CAPACITY];
  spq_pkg::entry_t      cell_next  [CAPACITY];
  spq_pkg::cell_stat_t  cell_stat  [CAPACITY];
  logic [CAPACITY-1:0]  ge_vec;
  logic                 any_ge;
  logic                 is_full;
  logic                 none_held;

  // Handshake
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_full   = (count == CAP);
  assign none_held = (count == '0);
  assign new_entry = '{value: item_value, prio: item_priority};

  // Command decode
  always_comb begin
    ctrl           = '0;
    ctrl.new_entry = new_entry;
    status_next    = spq_pkg::ST_OK;
    count_next     = count;
    if (accept) begin
      case (cmd)
        spq_pkg::CMD_INSERT: begin
          if (is_full) begin
            status_next = spq_pkg::ST_FULL;
          end else begin
            ctrl.do_insert = 1'b1;
            count_next     = count + CNT_W'(1);
          end
        end
        spq_pkg::CMD_REMOVE: begin
          if (none_held) begin
            status_next = spq_pkg::ST_EMPTY;
          end else begin
            ctrl.do_remove = 1'b1;
            count_next     = count - CNT_W'(1);
          end
        end
        spq_pkg::CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    logic            left_s;
    spq_pkg::entry_t right_e;

    if (i == 0) begin : g_front
      assign left_e = new_entry;
      assign left_s = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_s = cell_stat[i-1].shift;
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .strict_cmp  (i == 0),
      .valid       (CNT_W'(i) < count),
      .left_entry  (left_e),
      .left_shift  (left_s),
      .right_entry (right_e),
      .entry       (cell_entry[i]),
      .entry_next  (cell_next[i]),
      .stat        (cell_stat[i])
    );

    assign ge_vec[i] = cell_stat[i].ge;
  end

  assign any_ge = |ge_vec;

  // Back entry tracked on the side: it changes only when an insert lands last
  always_comb begin
    back_next = back;
    if (ctrl.do_insert && !any_ge) begin
      back_next = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    back <= back_next;
  end

  // Count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      entry_count <= 5'(count_next);
      is_empty    <= (count_next == '0);
      if (count_next == '0) begin
        front_value    <= '0;
        front_priority <= '0;
        back_value     <= '0;
        back_priority  <= '0;
      end else begin
        front_value    <= cell_next[0].value;
        front_priority <= cell_next[0].prio;
        back_value     <= back_next.value;
        back_priority  <= back_next.prio;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("occupancy above capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with occupancy");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == spq_pkg::CMD_INSERT && is_full) |=>
      (count == CAP && status == spq_pkg::ST_FULL))
    else $error("insert into full queue changed state");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_empty) |-> (front_priority <= back_priority))
    else $error("front less urgent than back");

endmodule
